// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

// ----- rtl/core/dsfp_pkg.sv -----
// ----------------------------------------------------------------------------
// dsfp_pkg
// Types, constants and the shared multiply-by-ten step of the decimal parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dsfp_pkg;

  localparam int unsigned MAX_PRECISION_DEF = 18;
  localparam int unsigned PREC_W            = 5;
  localparam logic [PREC_W-1:0] PREC_RESET  = 5'd6;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;

  localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_DIV10 = MAG_LIMIT / 64'd10;
  localparam logic [63:0] LIM_REM10 = MAG_LIMIT % 64'd10;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_SIGN  = 2'd1,
    PH_INT   = 2'd2,
    PH_FRAC  = 2'd3
  } dsfp_phase_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_BARE_MINUS = 3'd2,
    ST_BAD_INT    = 3'd3,
    ST_INT_OVF    = 3'd4,
    ST_BAD_FRAC   = 3'd5,
    ST_RES_OVF    = 3'd6
  } dsfp_status_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       last;
  } dsfp_in_t;

  typedef struct packed {
    logic signed [63:0] scaled_value;
    logic [2:0]         status;
  } dsfp_out_t;

  // Control part of a number in flight through the scaling pipeline.
  typedef struct packed {
    dsfp_status_e status;
    logic         neg;
    logic [63:0]  mag;
  } dsfp_job_t;

  typedef struct packed {
    logic        ovf;
    logic [63:0] value;
  } dsfp_mac_t;

  // acc * 10 + dig, with ovf set when the result would pass MAG_LIMIT.
  function automatic dsfp_mac_t dsfp_mac10(input logic [63:0] acc, input logic [3:0] dig);
    dsfp_mac_t   r;
    logic [63:0] lim;
    lim     = (dig > LIM_REM10[3:0]) ? (LIM_DIV10 - 64'd1) : LIM_DIV10;
    r.ovf   = (acc > lim);
    r.value = (acc << 3) + (acc << 1) + {60'd0, dig};
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dsfp_char_parser.sv -----
// ----------------------------------------------------------------------------
// dsfp_char_parser
// Consumes one character per transaction, builds the integer part and the
// fraction digits, and hands a finished number to the scaling pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dsfp_char_parser #(
  parameter int unsigned MAX_PRECISION = dsfp_pkg::MAX_PRECISION_DEF,
  parameter int unsigned FC_W          = $clog2(MAX_PRECISION + 1)
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  dsfp_pkg::dsfp_in_t           in_data_i,
  input  wire  [FC_W-1:0]              prec_i,
  output logic                         job_valid_o,
  input  wire                          job_ready_i,
  output dsfp_pkg::dsfp_job_t          job_o,
  output logic [MAX_PRECISION-1:0][3:0] job_digits_o,
  output logic [MAX_PRECISION-1:0]     job_take_o
);

  logic [63:0]                    int_q, int_d;
  logic [FC_W-1:0]                fc_q, fc_d;
  dsfp_pkg::dsfp_phase_e          phase_q, phase_d;
  logic                           neg_q, neg_d;
  dsfp_pkg::dsfp_status_e         err_q, err_d;
  logic [MAX_PRECISION-1:0][3:0]  digits_q, digits_d;

  logic                           job_valid_q;
  dsfp_pkg::dsfp_job_t            job_q, job_d;
  logic [MAX_PRECISION-1:0][3:0]  job_digits_q;
  logic [MAX_PRECISION-1:0]       job_take_q, take_d;

  logic                           accept;
  logic                           slot_free;
  logic [7:0]                     c;
  logic [7:0]                     c_off;
  logic [3:0]                     dig;
  logic                           is_digit;
  dsfp_pkg::dsfp_mac_t            mac;

  assign slot_free  = !job_valid_q || job_ready_i;
  assign in_stall_o = !slot_free;
  assign accept     = in_valid_i && slot_free;

  assign c        = in_data_i.char_code;
  assign c_off    = c - dsfp_pkg::CHAR_0;
  assign dig      = c_off[3:0];
  assign is_digit = (c >= dsfp_pkg::CHAR_0) && (c <= dsfp_pkg::CHAR_9);
  assign mac      = dsfp_pkg::dsfp_mac10(int_q, dig);

  always_comb begin
    int_d    = int_q;
    fc_d     = fc_q;
    phase_d  = phase_q;
    neg_d    = neg_q;
    err_d    = err_q;
    digits_d = digits_q;
    if (in_data_i.has_char && (err_q == dsfp_pkg::ST_OK)) begin
      if (phase_q == dsfp_pkg::PH_FRAC) begin
        // Fraction characters past the precision are dropped unchecked.
        if (fc_q < prec_i) begin
          if (is_digit) begin
            for (int i = 0; i < MAX_PRECISION; i++) begin
              if (fc_q == FC_W'(i)) begin
                digits_d[i] = dig;
              end
            end
            fc_d = fc_q + FC_W'(1);
          end else begin
            err_d = dsfp_pkg::ST_BAD_FRAC;
          end
        end
      end else if ((phase_q == dsfp_pkg::PH_START) && (c == dsfp_pkg::CHAR_MINUS)) begin
        neg_d   = 1'b1;
        phase_d = dsfp_pkg::PH_SIGN;
      end else if (c == dsfp_pkg::CHAR_DOT) begin
        phase_d = dsfp_pkg::PH_FRAC;
      end else if (is_digit) begin
        if (mac.ovf) begin
          err_d = dsfp_pkg::ST_INT_OVF;
        end else begin
          int_d = mac.value;
        end
        phase_d = dsfp_pkg::PH_INT;
      end else begin
        err_d = dsfp_pkg::ST_BAD_INT;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PRECISION; i++) begin
      take_d[i] = (FC_W'(i) < prec_i);
    end
    job_d.neg = neg_d;
    job_d.mag = int_d;
    if (err_d != dsfp_pkg::ST_OK) begin
      job_d.status = err_d;
    end else begin
      unique case (phase_d)
        dsfp_pkg::PH_START: job_d.status = dsfp_pkg::ST_EMPTY;
        dsfp_pkg::PH_SIGN:  job_d.status = dsfp_pkg::ST_BARE_MINUS;
        dsfp_pkg::PH_INT:   job_d.status = dsfp_pkg::ST_OK;
        dsfp_pkg::PH_FRAC:  job_d.status = dsfp_pkg::ST_OK;
        default:            job_d.status = dsfp_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q       <= '0;
      fc_q        <= '0;
      phase_q     <= dsfp_pkg::PH_START;
      neg_q       <= 1'b0;
      err_q       <= dsfp_pkg::ST_OK;
      digits_q    <= '0;
      job_valid_q <= 1'b0;
    end else begin
      if (accept && in_data_i.last) begin
        int_q    <= '0;
        fc_q     <= '0;
        phase_q  <= dsfp_pkg::PH_START;
        neg_q    <= 1'b0;
        err_q    <= dsfp_pkg::ST_OK;
        digits_q <= '0;
      end else if (accept) begin
        int_q    <= int_d;
        fc_q     <= fc_d;
        phase_q  <= phase_d;
        neg_q    <= neg_d;
        err_q    <= err_d;
        digits_q <= digits_d;
      end
      if (slot_free) begin
        job_valid_q <= accept && in_data_i.last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.last) begin
      job_q        <= job_d;
      job_digits_q <= digits_d;
      job_take_q   <= take_d;
    end
  end

  assign job_valid_o  = job_valid_q;
  assign job_o        = job_q;
  assign job_digits_o = job_digits_q;
  assign job_take_o   = job_take_q;

  `ASSERT_CLK(a_clear_after_last, accept && in_data_i.last |=>
              (phase_q == dsfp_pkg::PH_START) && (err_q == dsfp_pkg::ST_OK) && (fc_q == '0),
              "parse state not cleared after the last character")
  `ASSERT_CLK(a_error_sticky, (err_q != dsfp_pkg::ST_OK) && !(accept && in_data_i.last) |=>
              $stable(err_q) && $stable(int_q),
              "error code or integer changed after an error")
  `ASSERT_NEVER(a_fc_range, fc_q > FC_W'(MAX_PRECISION),
                "fraction digit count beyond the digit store")

endmodule

`default_nettype wire

// ----- rtl/core/dsfp_scale_stage.sv -----
// ----------------------------------------------------------------------------
// dsfp_scale_stage
// One step of the scaling pipeline: folds one fraction digit position into
// the magnitude (times ten plus digit) and flags result overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module dsfp_scale_stage #(
  parameter int unsigned MAX_PRECISION = dsfp_pkg::MAX_PRECISION_DEF,
  parameter int unsigned INDEX         = 0
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           up_valid_i,
  output logic                          up_ready_o,
  input  dsfp_pkg::dsfp_job_t           up_job_i,
  input  wire  [MAX_PRECISION-1:0][3:0] up_digits_i,
  input  wire  [MAX_PRECISION-1:0]      up_take_i,
  output logic                          dn_valid_o,
  input  wire                           dn_ready_i,
  output dsfp_pkg::dsfp_job_t           dn_job_o,
  output logic [MAX_PRECISION-1:0][3:0] dn_digits_o,
  output logic [MAX_PRECISION-1:0]      dn_take_o
);

  logic                          valid_q;
  dsfp_pkg::dsfp_job_t           job_q, job_d;
  logic [MAX_PRECISION-1:0][3:0] digits_q;
  logic [MAX_PRECISION-1:0]      take_q;
  dsfp_pkg::dsfp_mac_t           mac;
  logic                          load;

  assign up_ready_o = !valid_q || dn_ready_i;
  assign load       = up_valid_i && up_ready_o;
  assign mac        = dsfp_pkg::dsfp_mac10(up_job_i.mag, up_digits_i[INDEX]);

  // Positions at or past the precision pass the number through unchanged.
  always_comb begin
    job_d = up_job_i;
    if ((up_job_i.status == dsfp_pkg::ST_OK) && up_take_i[INDEX]) begin
      if (mac.ovf) begin
        job_d.status = dsfp_pkg::ST_RES_OVF;
      end else begin
        job_d.mag = mac.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q    <= job_d;
      digits_q <= up_digits_i;
      take_q   <= up_take_i;
    end
  end

  assign dn_valid_o  = valid_q;
  assign dn_job_o    = job_q;
  assign dn_digits_o = digits_q;
  assign dn_take_o   = take_q;

endmodule

`default_nettype wire

// ----- rtl/core/decimal_string_to_fixed_point_top.sv -----
// ----------------------------------------------------------------------------
// decimal_string_to_fixed_point_top
// Decimal text to signed scaled integer: value times ten to the precision.
// ----------------------------------------------------------------------------
// The block takes one ASCII character per cycle and accepts a new character
// on every clock as long as the scaling pipeline can advance. On the character
// marked last, the parsed number is registered in the parser and then enters
// a pipeline of MAX_PRECISION stages, each multiplying by ten and adding one
// fraction digit below the precision, before the output register holds the
// result; up to MAX_PRECISION + 2 numbers can be in flight at once. The
// precision register may be rewritten between characters; the value in force
// when the last character is taken sets the scaling of that number.
`default_nettype none
`include "assert_macros.svh"

module decimal_string_to_fixed_point_top #(
  parameter int unsigned MAX_PRECISION = dsfp_pkg::MAX_PRECISION_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [dsfp_pkg::PREC_W-1:0]    cfg_wdata_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  dsfp_pkg::dsfp_in_t             in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output dsfp_pkg::dsfp_out_t            out_data_o
);

  localparam int unsigned FC_W = $clog2(MAX_PRECISION + 1);

  logic [dsfp_pkg::PREC_W-1:0]   prec_q;
  logic [FC_W-1:0]               prec_eff;

  logic [MAX_PRECISION:0]        pipe_valid;
  logic [MAX_PRECISION:0]        pipe_ready;
  dsfp_pkg::dsfp_job_t           pipe_job    [MAX_PRECISION+1];
  logic [MAX_PRECISION-1:0][3:0] pipe_digits [MAX_PRECISION+1];
  logic [MAX_PRECISION-1:0]      pipe_take   [MAX_PRECISION+1];

  logic                          out_valid_q;
  dsfp_pkg::dsfp_out_t           out_q, out_d;
  logic                          out_ready;
  dsfp_pkg::dsfp_job_t           tail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prec_q <= dsfp_pkg::PREC_RESET;
    end else if (cfg_we_i) begin
      prec_q <= cfg_wdata_i;
    end
  end

  assign prec_eff = (prec_q > dsfp_pkg::PREC_W'(MAX_PRECISION)) ?
                    FC_W'(MAX_PRECISION) : prec_q[FC_W-1:0];

  dsfp_char_parser #(
    .MAX_PRECISION (MAX_PRECISION),
    .FC_W          (FC_W)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .prec_i       (prec_eff),
    .job_valid_o  (pipe_valid[0]),
    .job_ready_i  (pipe_ready[0]),
    .job_o        (pipe_job[0]),
    .job_digits_o (pipe_digits[0]),
    .job_take_o   (pipe_take[0])
  );

  for (genvar k = 0; k < MAX_PRECISION; k++) begin : g_stage
    dsfp_scale_stage #(
      .MAX_PRECISION (MAX_PRECISION),
      .INDEX         (k)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .up_valid_i  (pipe_valid[k]),
      .up_ready_o  (pipe_ready[k]),
      .up_job_i    (pipe_job[k]),
      .up_digits_i (pipe_digits[k]),
      .up_take_i   (pipe_take[k]),
      .dn_valid_o  (pipe_valid[k+1]),
      .dn_ready_i  (pipe_ready[k+1]),
      .dn_job_o    (pipe_job[k+1]),
      .dn_digits_o (pipe_digits[k+1]),
      .dn_take_o   (pipe_take[k+1])
    );
  end

  assign out_ready                 = !out_valid_q || !out_stall_i;
  assign pipe_ready[MAX_PRECISION] = out_ready;
  assign tail                      = pipe_job[MAX_PRECISION];

  always_comb begin
    out_d.status = tail.status;
    if (tail.status != dsfp_pkg::ST_OK) begin
      out_d.scaled_value = '0;
    end else if (tail.neg) begin
      out_d.scaled_value = -$signed(tail.mag);
    end else begin
      out_d.scaled_value = $signed(tail.mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= pipe_valid[MAX_PRECISION];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && pipe_valid[MAX_PRECISION]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_CLK(a_zero_on_error, out_valid_o && (out_data_o.status != 3'(dsfp_pkg::ST_OK)) |->
              (out_data_o.scaled_value == '0),
              "nonzero value reported with an error status")
  `ASSERT_CLK(a_tail_moves, out_ready && pipe_valid[MAX_PRECISION] |=> out_valid_q,
              "result lost between pipeline tail and output register")
  `ASSERT_NEVER(a_prec_range, prec_eff > FC_W'(MAX_PRECISION),
                "effective precision beyond the digit store")

endmodule

`default_nettype wire

// ----- tb/sv/decimal_parse_checker.sv -----
// ----------------------------------------------------------------------------
// decimal_parse_checker
// Watches the character, result and precision ports of the decimal parser,
// works out the scaled integer that each finished string must produce and
// compares every result transaction with it, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module decimal_parse_checker
  import dsfp_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire   [PREC_W-1:0] cfg_wdata_i,
  input  wire                in_valid_i,
  input  wire                in_stall_o,
  input  dsfp_in_t           in_data_i,
  input  wire                out_valid_o,
  input  wire                out_stall_i,
  input  dsfp_out_t          out_data_o,
  output int                 bad_results,
  output int                 numbers_in_flight
);

  logic [PREC_W-1:0] precision;
  logic [63:0]       int_part;
  logic [63:0]       frac_part;
  logic [4:0]        frac_digits;
  dsfp_phase_e       phase;
  logic              minus;
  dsfp_status_e      first_error;

  // Numbers whose last character has been taken but whose result has not
  // come out yet, oldest first.
  dsfp_out_t         numbers[$];

  function automatic logic [63:0] ten_to(input int unsigned e);
    logic [63:0] r;
    r = 64'd1;
    for (int unsigned i = 0; i < e; i++) r = r * 64'd10;
    return r;
  endfunction

  task automatic clear_number();
    int_part    = '0;
    frac_part   = '0;
    frac_digits = '0;
    phase       = PH_START;
    minus       = 1'b0;
    first_error = ST_OK;
  endtask

  task automatic take_int_char(input logic [7:0] c);
    logic [63:0] d;
    d = 64'(c - CHAR_0);
    if (c == CHAR_DOT) begin
      phase = PH_FRAC;
    end else if (c >= CHAR_0 && c <= CHAR_9) begin
      if (int_part > (MAG_LIMIT - d) / 64'd10) first_error = ST_INT_OVF;
      else int_part = int_part * 64'd10 + d;
      phase = PH_INT;
    end else begin
      first_error = ST_BAD_INT;
    end
  endtask

  task automatic take_char(input dsfp_in_t item);
    int unsigned p;
    logic [63:0] scale;
    logic [63:0] fv;
    logic [63:0] mag;
    dsfp_out_t   r;
    p = (precision > MAX_PRECISION_DEF) ? MAX_PRECISION_DEF : precision;
    if (item.has_char && first_error == ST_OK) begin
      case (phase)
        PH_START: begin
          if (item.char_code == CHAR_MINUS) begin
            minus = 1'b1;
            phase = PH_SIGN;
          end else begin
            take_int_char(item.char_code);
          end
        end
        PH_SIGN, PH_INT: begin
          take_int_char(item.char_code);
        end
        default: begin
          // Fraction characters past the precision are not looked at.
          if (frac_digits < p) begin
            if (item.char_code >= CHAR_0 && item.char_code <= CHAR_9) begin
              frac_part   = frac_part * 64'd10 + 64'(item.char_code - CHAR_0);
              frac_digits = frac_digits + 5'd1;
            end else begin
              first_error = ST_BAD_FRAC;
            end
          end
        end
      endcase
    end
    if (item.last) begin
      r.scaled_value = '0;
      if (first_error != ST_OK) begin
        r.status = first_error;
      end else if (phase == PH_START) begin
        r.status = ST_EMPTY;
      end else if (phase == PH_SIGN) begin
        r.status = ST_BARE_MINUS;
      end else begin
        scale = ten_to(p);
        fv    = frac_part;
        if (frac_digits < p) fv = fv * ten_to(p - frac_digits);
        else if (frac_digits > p) fv = fv / ten_to(frac_digits - p);
        if (int_part > (MAG_LIMIT - fv) / scale) begin
          r.status = ST_RES_OVF;
        end else begin
          mag            = int_part * scale + fv;
          r.scaled_value = minus ? -mag : mag;
          r.status       = ST_OK;
        end
      end
      numbers.push_back(r);
      clear_number();
    end
  endtask

  task automatic check_result(input dsfp_out_t got);
    dsfp_out_t want;
    if (numbers.size() == 0) begin
      $display("%0t: result with nothing expected: expected none, got value %0d status %0d",
               $time, $signed(got.scaled_value), got.status);
      bad_results++;
    end else begin
      want = numbers.pop_front();
      if (got.scaled_value !== want.scaled_value) begin
        $display("%0t: scaled_value mismatch: expected %0d, got %0d", $time,
                 $signed(want.scaled_value), $signed(got.scaled_value));
        bad_results++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d", $time,
                 want.status, got.status);
        bad_results++;
      end
    end
  endtask

  // The register value before this edge applies to a character taken at it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      precision = PREC_RESET;
      clear_number();
      numbers.delete();
    end else begin
      if (in_valid_i && !in_stall_o) take_char(in_data_i);
      if (cfg_we_i) precision = cfg_wdata_i;
      if (out_valid_o && !out_stall_i) check_result(out_data_o);
    end
    numbers_in_flight = numbers.size();
  end

endmodule

// ----- tb/sv/tb_decimal_string_to_fixed_point_top.sv -----
// ----------------------------------------------------------------------------
// tb_decimal_string_to_fixed_point_top
// Feeds the decimal parser with directed and random number strings under
// several precision settings, with random gaps and stalls on both channels,
// and reports the verdict of the checker that sits beside it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_decimal_string_to_fixed_point_top;
  import dsfp_pkg::*;

  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int PHASE_CHARS   = 56;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [PREC_W-1:0] cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  dsfp_in_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  dsfp_out_t         out_data;

  int                bad_results;
  int                numbers_in_flight;
  int                chars_sent = 0;
  bit                tx_fast    = 1'b0;
  bit                rx_fast    = 1'b0;
  bit                hold_rx    = 1'b0;
  logic [7:0]        text[$];

  always #5 clk = ~clk;

  decimal_string_to_fixed_point_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  decimal_parse_checker checker_i (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .in_data_i         (in_data),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .out_data_o        (out_data),
    .bad_results       (bad_results),
    .numbers_in_flight (numbers_in_flight)
  );

  task automatic send_char(input logic [7:0] c, input bit has, input bit is_last);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_fast = !tx_fast;
    gap = tx_fast ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_code: c, has_char: has, last: is_last};
    do @(posedge clk); while (in_stall);
    if (has) chars_sent++;
  endtask

  task automatic send_literal(input string s);
    if (s.len() == 0) send_char(8'h00, 1'b0, 1'b1);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b1, i == s.len() - 1);
  endtask

  // Sends the text buffer as one string, sometimes with blank transactions
  // in between or a blank transaction carrying the end marker.
  task automatic send_text();
    bit blank_end;
    blank_end = ($urandom_range(0, 7) == 0);
    foreach (text[i]) begin
      if ($urandom_range(0, 15) == 0) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_char(text[i], 1'b1, (i == text.size() - 1) && !blank_end);
    end
    if (blank_end || text.size() == 0) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic push_digits(input int n);
    repeat (n) text.push_back(8'(CHAR_0 + $urandom_range(0, 9)));
  endtask

  // Integer parts around the largest magnitude, on both sides of it.
  task automatic push_near_limit();
    string lim;
    int    keep;
    lim = "9223372036854775807";
    case ($urandom_range(0, 3))
      0: begin
        for (int i = 0; i < 19; i++) text.push_back(lim[i]);
        push_digits(1);
      end
      1: begin
        for (int i = 0; i < 18; i++) text.push_back(lim[i]);
      end
      default: begin
        keep = $urandom_range(16, 19);
        for (int i = 0; i < keep; i++) text.push_back(lim[i]);
        push_digits(19 - keep);
      end
    endcase
  endtask

  task automatic make_number(input int p);
    int m;
    text.delete();
    if ($urandom_range(0, 2) == 0) text.push_back(CHAR_MINUS);
    if ($urandom_range(0, 6) == 0) push_near_limit();
    else push_digits(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
    if ($urandom_range(0, 2) != 0) begin
      text.push_back(CHAR_DOT);
      m = $urandom_range(0, p + 3);
      push_digits(m);
      if (m >= p && $urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic break_number();
    int pos;
    pos = $urandom_range(0, text.size());
    case ($urandom_range(0, 2))
      0: text.insert(pos, 8'($urandom_range(0, 255)));
      1: begin
        if (pos < text.size()) text[pos] = 8'($urandom_range(0, 255));
        else text.push_back(8'($urandom_range(0, 255)));
      end
      default: text.insert(pos, ($urandom_range(0, 1) == 1) ? CHAR_MINUS : CHAR_DOT);
    endcase
  endtask

  // The last character may leave the block busy with its scaling, so a
  // settling stretch follows the last result before anything is rewritten.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (numbers_in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_precision(input logic [PREC_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [PREC_W-1:0] prec);
    int p;
    int target;
    wait_idle();
    set_precision(prec);
    p      = (prec > MAX_PRECISION_DEF) ? MAX_PRECISION_DEF : prec;
    target = chars_sent + PHASE_CHARS;
    while (chars_sent < target) begin
      make_number(p);
      if ($urandom_range(0, 3) == 0) break_number();
      send_text();
    end
  endtask

  // Single-digit numbers back to back while the receiver holds off, so the
  // scaling pipeline fills and the input side has to stall.
  task automatic fill_pipeline();
    wait_idle();
    set_precision(5'd2);
    hold_rx = 1'b1;
    repeat (60) begin
      in_valid <= 1'b1;
      in_data  <= '{char_code: 8'(CHAR_0 + $urandom_range(0, 9)), has_char: 1'b1,
                    last: 1'b1};
      do @(posedge clk); while (in_stall);
      chars_sent++;
    end
  endtask

  initial begin
    int k;
    wait (rst_n);
    forever begin
      if (hold_rx) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) rx_fast = !rx_fast;
      k = rx_fast ? 0 : $urandom_range(0, 19);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [PREC_W-1:0] plan[8];
    int leftover;
    plan = '{5'd0, 5'd18, 5'd31, 5'd1, 5'd12, 5'd19, 5'd3, 5'd6};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings at the reset precision.
    send_literal("");
    send_literal("-");
    send_literal(".5");
    send_literal("-.5");
    send_literal(".");
    send_literal("5.");
    send_literal("--");
    send_literal("1..");
    send_char(CHAR_0 + 8'd1, 1'b1, 1'b0);
    send_char(CHAR_DOT, 1'b1, 1'b0);
    send_char(8'h00, 1'b1, 1'b1);
    send_char(CHAR_0 + 8'd7, 1'b1, 1'b0);
    send_char(8'h00, 1'b0, 1'b1);
    send_char(8'hFF, 1'b1, 1'b1);

    foreach (plan[i]) begin
      run_phase(plan[i]);
      if (i == 2) fill_pipeline();
    end
    run_phase(5'($urandom_range(0, 31)));

    in_valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && numbers_in_flight != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    leftover = numbers_in_flight;
    if (leftover != 0) $display("%0t: %0d expected results never arrived", $time, leftover);
    if (bad_results == 0 && leftover == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
